>>> sv/kicker_charge_fire_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the kicker charge and fire controller.
// They expect clk_i and rst_ni in the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef KICKER_CHARGE_FIRE_CONTROLLER_UNIT_MACROS_SVH
`define KICKER_CHARGE_FIRE_CONTROLLER_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define KCFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication that must hold in the same cycle.
`define KCFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication that must hold in the next cycle.
`define KCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/kcfc_pkg.sv
// ----------------------------------------------------------------------------
// kcfc_pkg
// Types and constants shared by the kicker charge and fire controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcfc_pkg;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_CHARGING = 2'd1,
    MODE_READY    = 2'd2,
    MODE_KICKING  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CHARGE = 2'd1,
    OP_STOP   = 2'd2,
    OP_SHOOT  = 2'd3
  } op_e;

  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned POWER_W = 7;
  localparam int unsigned PROD_W  = POWER_W + DATA_W;

  localparam logic [IDX_W-1:0] REG_KICK_POWER      = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFF_PERIOD      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CHARGING_PERIOD = 3'd2;
  localparam logic [IDX_W-1:0] REG_READY_PERIOD    = 3'd3;
  localparam logic [IDX_W-1:0] REG_KICKING_PERIOD  = 3'd4;
  localparam logic [IDX_W-1:0] REG_KICK_UNIT_TIME  = 3'd5;
  localparam logic [IDX_W-1:0] REG_CHIP_UNIT_TIME  = 3'd6;

  localparam logic [POWER_W-1:0] POWER_MIN = 7'd1;
  localparam logic [POWER_W-1:0] POWER_MAX = 7'd100;

  localparam logic [POWER_W-1:0] RST_KICK_POWER      = 7'd1;
  localparam logic [DATA_W-1:0]  RST_OFF_PERIOD      = 16'd1000;
  localparam logic [DATA_W-1:0]  RST_CHARGING_PERIOD = 16'd100;
  localparam logic [DATA_W-1:0]  RST_READY_PERIOD    = 16'd1000;
  localparam logic [DATA_W-1:0]  RST_KICKING_PERIOD  = 16'd100;
  localparam logic [DATA_W-1:0]  RST_KICK_UNIT_TIME  = 16'd10;
  localparam logic [DATA_W-1:0]  RST_CHIP_UNIT_TIME  = 16'd10;

  typedef struct packed {
    logic [POWER_W-1:0] kick_power;
    logic [DATA_W-1:0]  off_period;
    logic [DATA_W-1:0]  charging_period;
    logic [DATA_W-1:0]  ready_period;
    logic [DATA_W-1:0]  kicking_period;
    logic [DATA_W-1:0]  kick_unit_time;
    logic [DATA_W-1:0]  chip_unit_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       use_chipper;
    logic       charge_done_n;
  } in_t;

  typedef struct packed {
    logic       kick_drive;
    logic       chip_drive;
    logic       charge_drive;
    logic [1:0] mode;
    logic       is_charged;
    logic       step_ran;
  } res_t;

endpackage

>>> sv/kcfc_if.sv
// ----------------------------------------------------------------------------
// kcfc channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kcfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       use_chipper;
  logic       charge_done_n;

  modport source (output valid, output operation, output use_chipper,
                  output charge_done_n, input ready);
  modport sink   (input valid, input operation, input use_chipper,
                  input charge_done_n, output ready);
endinterface

interface kcfc_out_if;
  logic       valid;
  logic       ready;
  logic       kick_drive;
  logic       chip_drive;
  logic       charge_drive;
  logic [1:0] mode;
  logic       is_charged;
  logic       step_ran;

  modport source (output valid, output kick_drive, output chip_drive,
                  output charge_drive, output mode, output is_charged,
                  output step_ran, input ready);
  modport sink   (input valid, input kick_drive, input chip_drive,
                  input charge_drive, input mode, input is_charged,
                  input step_ran, output ready);
endinterface

interface kcfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/kicker_charge_fire_controller_unit.sv
// A command is captured in the input register and its result in the result register.
// Throughput: one command per cycle while results are taken; the mode and timer
// update is a single registered step from the input register into the result register.
// Reset clears mode, timer and pin levels and restores the register
// defaults at once; no clearing pass follows reset.
// ----------------------------------------------------------------------------
// kicker_charge_fire_controller_unit
// Top level of the solenoid kicker charge and fire controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kicker_charge_fire_controller_unit
  import kcfc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kcfc_in_if.sink    in_i,
  kcfc_out_if.source out_o,
  kcfc_cfg_if.sink   cfg_i
);

  cfg_t cfg;
  in_t  in_data;
  res_t res;

  kcfc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_o       (cfg)
  );

  assign in_data.operation     = in_i.operation;
  assign in_data.use_chipper   = in_i.use_chipper;
  assign in_data.charge_done_n = in_i.charge_done_n;

  kcfc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res)
  );

  assign out_o.kick_drive   = res.kick_drive;
  assign out_o.chip_drive   = res.chip_drive;
  assign out_o.charge_drive = res.charge_drive;
  assign out_o.mode         = res.mode;
  assign out_o.is_charged   = res.is_charged;
  assign out_o.step_ran     = res.step_ran;

endmodule

>>> sv/kcfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// kcfc_cfg_regs
// Register file for the periods, unit times and shot power.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcfc_cfg_regs
  import kcfc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  output cfg_t              cfg_o
);

  cfg_t               cfg_q, cfg_d;
  logic [POWER_W-1:0] power_raw;
  logic [POWER_W-1:0] power_sat;

  assign cfg_ready_o = 1'b1;
  assign power_raw   = cfg_data_i[POWER_W-1:0];

  always_comb begin
    if (power_raw < POWER_MIN) begin
      power_sat = POWER_MIN;
    end else if (power_raw > POWER_MAX) begin
      power_sat = POWER_MAX;
    end else begin
      power_sat = power_raw;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KICK_POWER:      cfg_d.kick_power      = power_sat;
        REG_OFF_PERIOD:      cfg_d.off_period      = cfg_data_i;
        REG_CHARGING_PERIOD: cfg_d.charging_period = cfg_data_i;
        REG_READY_PERIOD:    cfg_d.ready_period    = cfg_data_i;
        REG_KICKING_PERIOD:  cfg_d.kicking_period  = cfg_data_i;
        REG_KICK_UNIT_TIME:  cfg_d.kick_unit_time  = cfg_data_i;
        REG_CHIP_UNIT_TIME:  cfg_d.chip_unit_time  = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kick_power      <= RST_KICK_POWER;
      cfg_q.off_period      <= RST_OFF_PERIOD;
      cfg_q.charging_period <= RST_CHARGING_PERIOD;
      cfg_q.ready_period    <= RST_READY_PERIOD;
      cfg_q.kicking_period  <= RST_KICKING_PERIOD;
      cfg_q.kick_unit_time  <= RST_KICK_UNIT_TIME;
      cfg_q.chip_unit_time  <= RST_CHIP_UNIT_TIME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/kcfc_core.sv
// ----------------------------------------------------------------------------
// kcfc_core
// Input register, mode and timer update, and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcfc_core
  import kcfc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

`include "kicker_charge_fire_controller_unit_macros.svh"

  localparam int unsigned WIDE_W = (TIMER_BITS > PROD_W) ? TIMER_BITS : PROD_W;
  localparam logic [WIDE_W-1:0] TMAX_WIDE = WIDE_W'({TIMER_BITS{1'b1}});

  // Handshake and payload registers.
  logic in_valid_q, out_valid_q;
  in_t  in_q;
  res_t res_q;
  logic advance;

  // Controller state.
  mode_e                 mode_q, mode_d;
  logic                  charged_q, charged_d;
  logic [TIMER_BITS-1:0] count_q, count_d;
  logic                  running_q, running_d;
  logic                  kick_q, kick_d;
  logic                  chip_q, chip_d;
  logic                  charge_q, charge_d;
  logic                  ran_d;

  op_e                   op;
  logic [DATA_W-1:0]     unit_time;
  logic [PROD_W-1:0]     pulse_prod;
  logic [WIDE_W-1:0]     pulse_wide;
  logic [TIMER_BITS-1:0] pulse_ticks;
  res_t                  res_d;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign op         = op_e'(in_q.operation);

  // Shot length, saturated to the timer range.
  assign unit_time   = in_q.use_chipper ? cfg_i.chip_unit_time : cfg_i.kick_unit_time;
  assign pulse_prod  = PROD_W'(cfg_i.kick_power) * PROD_W'(unit_time);
  assign pulse_wide  = WIDE_W'(pulse_prod);
  assign pulse_ticks = (pulse_wide > TMAX_WIDE) ? {TIMER_BITS{1'b1}}
                                                : pulse_wide[TIMER_BITS-1:0];

  // Next state. The command is applied first, then the callback step if one
  // is due, which sees the mode that the command left.
  always_comb begin
    logic do_cb;
    do_cb     = 1'b0;
    mode_d    = mode_q;
    charged_d = charged_q;
    count_d   = count_q;
    running_d = running_q;
    kick_d    = kick_q;
    chip_d    = chip_q;
    charge_d  = charge_q;

    case (op)
      OP_TICK: begin
        if (running_q) begin
          if (count_q == '0) begin
            do_cb = 1'b1;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
      end
      OP_CHARGE: begin
        charged_d = 1'b0;
        mode_d    = MODE_CHARGING;
        kick_d    = 1'b0;
        chip_d    = 1'b0;
        charge_d  = 1'b1;
        do_cb     = 1'b1;
      end
      OP_STOP: begin
        charged_d = 1'b0;
        mode_d    = MODE_OFF;
        kick_d    = 1'b0;
        chip_d    = 1'b0;
        charge_d  = 1'b0;
        running_d = 1'b0;
      end
      default: begin
        if (mode_q == MODE_READY) begin
          mode_d    = MODE_KICKING;
          charge_d  = 1'b0;
          if (in_q.use_chipper) begin
            chip_d = 1'b1;
          end else begin
            kick_d = 1'b1;
          end
          count_d   = pulse_ticks;
          running_d = 1'b1;
        end
      end
    endcase

    if (do_cb) begin
      running_d = 1'b1;
      unique case (mode_d)
        MODE_READY: begin
          charged_d = !charged_d;
          charge_d  = !charged_d;
          count_d   = TIMER_BITS'(cfg_i.ready_period);
        end
        MODE_CHARGING: begin
          if (!in_q.charge_done_n) begin
            charge_d  = 1'b0;
            charged_d = 1'b1;
            mode_d    = MODE_READY;
          end else begin
            kick_d    = 1'b0;
            chip_d    = 1'b0;
            charge_d  = 1'b1;
            charged_d = 1'b0;
          end
          count_d = TIMER_BITS'(cfg_i.charging_period);
        end
        MODE_KICKING: begin
          kick_d  = 1'b0;
          chip_d  = 1'b0;
          mode_d  = MODE_CHARGING;
          count_d = TIMER_BITS'(cfg_i.kicking_period);
        end
        MODE_OFF: begin
          kick_d   = 1'b0;
          chip_d   = 1'b0;
          charge_d = 1'b0;
          count_d  = TIMER_BITS'(cfg_i.off_period);
        end
      endcase
    end
    ran_d = do_cb;
  end

  // Result fields show the state after the item.
  always_comb begin
    res_d.kick_drive   = kick_d;
    res_d.chip_drive   = chip_d;
    res_d.charge_drive = charge_d;
    res_d.mode         = mode_d;
    res_d.is_charged   = charged_d;
    res_d.step_ran     = ran_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_OFF;
      charged_q   <= 1'b0;
      count_q     <= '0;
      running_q   <= 1'b0;
      kick_q      <= 1'b0;
      chip_q      <= 1'b0;
      charge_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
        charged_q   <= charged_d;
        count_q     <= count_d;
        running_q   <= running_d;
        kick_q      <= kick_d;
        chip_q      <= chip_d;
        charge_q    <= charge_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  `KCFC_ASSERT_IMPL(a_solenoids_only_kicking, mode_q != MODE_KICKING, !kick_q && !chip_q, "solenoid driven outside kicking mode")
  `KCFC_ASSERT_ALWAYS(a_one_solenoid, !(kick_q && chip_q), "kick and chip driven together")
  `KCFC_ASSERT_IMPL(a_stopped_only_off, !running_q, mode_q == MODE_OFF, "timer stopped outside off mode")
  `KCFC_ASSERT_NEXT(a_step_restarts_timer, advance && ran_d, running_q, "callback left timer stopped")
  `KCFC_ASSERT_NEXT(a_held_item_kept, in_valid_q && !advance, in_valid_q, "stalled command was dropped")

endmodule
